FILE: rtl/dstq_pkg.sv
package dstq_pkg;

   // Widths of the word fields.
   localparam int TIME_BITS         = 48;
   localparam int DELAY_BITS        = 32;
   localparam int HANDLE_FIELD_BITS = 8;
   localparam int NEXT_BITS         = TIME_BITS + 1;
   localparam int COUNT_FIELD_BITS  = 5;
   localparam int OUTCOME_BITS      = 2;

   localparam int REQ_TDATA_BITS = 88;
   localparam int RSP_TDATA_BITS = 64;

   // Defaults for the top level parameters.
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_HANDLE_BITS = 8;

   // Request kinds (req_tuser).
   localparam logic REQ_SCHEDULE = 1'b0;
   localparam logic REQ_EXPIRE   = 1'b1;

   // Result outcomes (rsp_tuser).
   localparam logic [OUTCOME_BITS-1:0] OUT_SCHEDULED = 2'd0;
   localparam logic [OUTCOME_BITS-1:0] OUT_REJECTED  = 2'd1;
   localparam logic [OUTCOME_BITS-1:0] OUT_EXPIRED   = 2'd2;
   localparam logic [OUTCOME_BITS-1:0] OUT_NONE_DUE  = 2'd3;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage

FILE: rtl/deadline_sorted_timer_queue.sv
// Deadline-sorted timer queue. Up to QUEUE_DEPTH timers sit in a row of cells,
// cell 0 holding the earliest deadline. A schedule word (req_tuser = 0) takes
// deadline = now_us + max(delay_us, 0), saturated at 2^48-1, and inserts it after
// all timers with an equal deadline; when the queue is full it returns a reject
// word instead. An expire word (req_tuser = 1) pops every timer due at or before
// now_us, one result word per handle with rsp_tlast on the final one, or returns
// a single nothing-due word. Each result carries the earliest remaining deadline
// (all ones when empty) and the pending count. A schedule first registers the
// deadline add, then inserts in parallel across the cell row; an expire first
// registers now_us, then pops the due timers in turn, the row shifting one entry
// toward the head per cycle while the output register is free. A new request is
// taken only when the previous one has produced its last result word into the
// output register; rsp_tready low stalls both the insert and the pops.
module deadline_sorted_timer_queue #(
   parameter int QUEUE_DEPTH = dstq_pkg::DEF_QUEUE_DEPTH,
   parameter int HANDLE_BITS = dstq_pkg::DEF_HANDLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [47:0] now_us, [79:48] delay_us, [87:80] timer_handle
   input  logic [dstq_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   // [0] req_type
   input  logic                                   req_tuser,
   // result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [7:0] expired_handle, [56:8] next_deadline, [61:57] pending_count, [63:62] zero
   output logic [dstq_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   // [1:0] outcome
   output logic [dstq_pkg::OUTCOME_BITS-1:0]      rsp_tuser,
   output logic                                   rsp_tlast
);
   import dstq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCHED  = 2'd1;
   localparam logic [1:0] ST_EXPIRE = 2'd2;

   // control state
   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request holding registers
   logic [TIME_BITS-1:0]   key_ff, key_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;

   // output word register
   logic [OUTCOME_BITS-1:0]     rsp_outcome_ff, rsp_outcome_in;
   logic [HANDLE_FIELD_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [NEXT_BITS-1:0]        rsp_next_ff, rsp_next_in;
   logic [COUNT_FIELD_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                        rsp_last_ff, rsp_last_in;

   // request fields
   logic [TIME_BITS-1:0]         req_now;
   logic [DELAY_BITS-1:0]        req_delay;
   logic [HANDLE_FIELD_BITS-1:0] req_handle;
   logic [TIME_BITS:0]           due_sum;

   // cell row
   cell_ctrl_type        ctrl;
   logic [TIME_BITS-1:0]   cell_deadline [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle   [QUEUE_DEPTH];
   logic                   cell_le       [QUEUE_DEPTH];
   logic                   cell_occ      [QUEUE_DEPTH];

   logic req_fire;
   logic out_free;
   logic full;

   assign req_now    = req_tdata[TIME_BITS-1:0];
   assign req_delay  = req_tdata[TIME_BITS +: DELAY_BITS];
   assign req_handle = req_tdata[TIME_BITS+DELAY_BITS +: HANDLE_FIELD_BITS];

   // Clamp a negative delay to zero, then add with one carry bit for saturation.
   assign due_sum = {1'b0, req_now}
                  + (req_delay[DELAY_BITS-1] ? '0 : (TIME_BITS+1)'(req_delay));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (count_ff == CW'(QUEUE_DEPTH));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      key_in         = key_ff;
      handle_in      = handle_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_next_in    = rsp_next_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      ctrl           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               handle_in = HANDLE_BITS'(req_handle);
               if (req_tuser == REQ_EXPIRE) begin
                  key_in   = req_now;
                  state_in = ST_EXPIRE;
               end else begin
                  key_in   = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];
                  state_in = ST_SCHED;
               end
            end
         end
         ST_SCHED: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
               if (full) begin
                  // drop the request, report the queue as it stands
                  rsp_outcome_in = OUT_REJECTED;
                  rsp_next_in    = {1'b0, cell_deadline[0]};
                  rsp_count_in   = COUNT_FIELD_BITS'(count_ff);
               end else begin
                  ctrl.insert    = 1'b1;
                  count_in       = count_ff + 1'b1;
                  rsp_outcome_in = OUT_SCHEDULED;
                  // new entry becomes head if the queue is empty or it is strictly earlier than the old head
                  rsp_next_in    = {1'b0, cell_le[0] ? cell_deadline[0] : key_ff};
                  rsp_count_in   = COUNT_FIELD_BITS'(count_ff + 1'b1);
               end
            end
         end
         ST_EXPIRE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (cell_le[0]) begin
                  // pop the head and advance the row
                  ctrl.pop       = 1'b1;
                  count_in       = count_ff - 1'b1;
                  rsp_outcome_in = OUT_EXPIRED;
                  rsp_handle_in  = HANDLE_FIELD_BITS'(cell_handle[0]);
                  rsp_next_in    = cell_occ[1] ? {1'b0, cell_deadline[1]} : '1;
                  rsp_count_in   = COUNT_FIELD_BITS'(count_ff - 1'b1);
                  rsp_last_in    = !cell_le[1];
                  if (!cell_le[1]) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  // only reached before any pop: nothing due
                  rsp_outcome_in = OUT_NONE_DUE;
                  rsp_handle_in  = '0;
                  rsp_next_in    = cell_occ[0] ? {1'b0, cell_deadline[0]} : '1;
                  rsp_count_in   = COUNT_FIELD_BITS'(count_ff);
                  rsp_last_in    = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      handle_ff      <= handle_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_next_ff    <= rsp_next_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Row of cells; cell i is occupied while i < count.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                   prev_le;
      logic [TIME_BITS-1:0]   prev_deadline;
      logic [HANDLE_BITS-1:0] prev_handle;
      logic [TIME_BITS-1:0]   next_deadline;
      logic [HANDLE_BITS-1:0] next_handle;

      assign cell_occ[i] = (count_ff > CW'(i));

      if (i == 0) begin : g_head
         assign prev_le       = 1'b1;
         assign prev_deadline = key_ff;
         assign prev_handle   = handle_ff;
      end else begin : g_body
         assign prev_le       = cell_le[i-1];
         assign prev_deadline = cell_deadline[i-1];
         assign prev_handle   = cell_handle[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_deadline = cell_deadline[i];
         assign next_handle   = cell_handle[i];
      end else begin : g_inner
         assign next_deadline = cell_deadline[i+1];
         assign next_handle   = cell_handle[i+1];
      end

      dstq_cell #(
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .key           (key_ff),
         .new_deadline  (key_ff),
         .new_handle    (handle_ff),
         .occupied      (cell_occ[i]),
         .prev_le       (prev_le),
         .prev_deadline (prev_deadline),
         .prev_handle   (prev_handle),
         .next_deadline (next_deadline),
         .next_handle   (next_handle),
         .deadline      (cell_deadline[i]),
         .handle        (cell_handle[i]),
         .le            (cell_le[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_next_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_outcome_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/dstq_cell.sv
module dstq_cell #(
   parameter int HANDLE_BITS = dstq_pkg::DEF_HANDLE_BITS
) (
   input  logic                            clock,
   input  dstq_pkg::cell_ctrl_type         ctrl,
   input  logic [dstq_pkg::TIME_BITS-1:0]  key,
   input  logic [dstq_pkg::TIME_BITS-1:0]  new_deadline,
   input  logic [HANDLE_BITS-1:0]          new_handle,
   input  logic                            occupied,
   input  logic                            prev_le,
   input  logic [dstq_pkg::TIME_BITS-1:0]  prev_deadline,
   input  logic [HANDLE_BITS-1:0]          prev_handle,
   input  logic [dstq_pkg::TIME_BITS-1:0]  next_deadline,
   input  logic [HANDLE_BITS-1:0]          next_handle,
   output logic [dstq_pkg::TIME_BITS-1:0]  deadline,
   output logic [HANDLE_BITS-1:0]          handle,
   output logic                            le
);
   import dstq_pkg::*;

   logic [TIME_BITS-1:0]   deadline_ff, deadline_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;

   // Entry is held and due no later than the key.
   assign le = occupied && (deadline_ff <= key);

   always_comb begin
      deadline_in = deadline_ff;
      handle_in   = handle_ff;
      if (ctrl.pop) begin
         deadline_in = next_deadline;
         handle_in   = next_handle;
      end else if (ctrl.insert) begin
         if (!prev_le) begin
            // shift right to open the slot upstream
            deadline_in = prev_deadline;
            handle_in   = prev_handle;
         end else if (!le) begin
            deadline_in = new_deadline;
            handle_in   = new_handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      handle_ff   <= handle_in;
   end

   assign deadline = deadline_ff;
   assign handle   = handle_ff;

endmodule

FILE: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dstq_pkg::*;

   localparam int DEPTH = DEF_QUEUE_DEPTH;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [NEXT_BITS-1:0] NO_DEADLINE = '1;
   localparam int RANDOM_PER_PHASE = 125;
   localparam int PRESSURE_CYCLES = 400;

   // One result word, split into its fields.
   typedef struct packed {
      logic [OUTCOME_BITS-1:0]      outcome;
      logic [HANDLE_FIELD_BITS-1:0] handle;
      logic [NEXT_BITS-1:0]         next_deadline;
      logic [COUNT_FIELD_BITS-1:0]  count;
      logic                         last;
   } timer_result_type;

   // One row of the directed part; typed rows carry their single result word.
   typedef struct packed {
      logic                         kind;
      logic [TIME_BITS-1:0]         now;
      logic [DELAY_BITS-1:0]        delay;
      logic [HANDLE_FIELD_BITS-1:0] handle;
      logic                         typed;
      logic [OUTCOME_BITS-1:0]      outcome;
      logic [HANDLE_FIELD_BITS-1:0] out_handle;
      logic [NEXT_BITS-1:0]         next_deadline;
      logic [COUNT_FIELD_BITS-1:0]  count;
   } timer_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;   // [47:0] now_us, [79:48] delay_us, [87:80] handle
   logic                      req_tuser;   // [0] req_type
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;   // [7:0] handle, [56:8] next, [61:57] count
   logic [OUTCOME_BITS-1:0]   rsp_tuser;   // [1:0] outcome
   logic                      rsp_tlast;

   // Shadow copy of the timer row, head at index 0.
   logic [TIME_BITS-1:0]         timer_deadline [DEPTH];
   logic [HANDLE_FIELD_BITS-1:0] timer_owner [DEPTH];
   int                           timer_total;

   // Words still owed by the block, oldest first, and the words of the current request.
   timer_result_type outcome_backlog [$];
   timer_result_type step_words [$];

   int  failures;
   int  requests_sent;
   int  outcome_seen [4];
   int  send_idle_pct;
   int  stall_pct;
   bit  pressure_go;
   bit  hold_rsp;
   logic [TIME_BITS-1:0] clock_now;

   timer_row_type directed_rows [0:24] = '{
      // expire on an empty queue: nothing due, no deadline pending
      '{REQ_EXPIRE, 48'd0, 32'd0, 8'h00, 1'b1, OUT_NONE_DUE, 8'h00, NO_DEADLINE, 5'd0},
      // most negative delay counts as zero
      '{REQ_SCHEDULE, 48'd0, 32'h8000_0000, 8'hFF, 1'b1, OUT_SCHEDULED, 8'h00, 49'd0, 5'd1},
      '{REQ_EXPIRE, 48'd0, 32'd0, 8'h00, 1'b1, OUT_EXPIRED, 8'hFF, NO_DEADLINE, 5'd0},
      // deadline saturates at the top of the time range
      '{REQ_SCHEDULE, TIME_MAX, 32'h7FFF_FFFF, 8'h01, 1'b1, OUT_SCHEDULED, 8'h00,
        {1'b0, TIME_MAX}, 5'd1},
      '{REQ_EXPIRE, TIME_MAX - 48'd1, 32'd0, 8'h00, 1'b1, OUT_NONE_DUE, 8'h00,
        {1'b0, TIME_MAX}, 5'd1},
      '{REQ_EXPIRE, TIME_MAX, 32'd0, 8'h00, 1'b1, OUT_EXPIRED, 8'h01, NO_DEADLINE, 5'd0},
      // fill the row with ties and out-of-order deadlines
      '{REQ_SCHEDULE, 48'd1000, 32'd500, 8'h00, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd100, 8'h55, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd500, 8'hAA, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd0, 8'h01, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd300, 8'h02, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd500, 8'h03, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd100, 8'h04, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd7, 8'h05, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd900, 8'h06, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd300, 8'h07, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'hFFFF_FFFF, 8'h08, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0,
        5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd500, 8'h09, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd2000, 8'h0A, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd100, 8'h0B, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'd0, 8'h0C, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_SCHEDULE, 48'd1000, 32'h7FFF_FFFF, 8'h0D, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0,
        5'd0},
      // one more on a full queue gets rejected
      '{REQ_SCHEDULE, 48'd1000, 32'd1, 8'hEE, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      // pop a run of due timers, ties in arrival order, then flush the rest
      '{REQ_EXPIRE, 48'd1500, 32'd0, 8'h00, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0},
      '{REQ_EXPIRE, TIME_MAX, 32'd0, 8'h00, 1'b0, OUT_SCHEDULED, 8'h00, 49'd0, 5'd0}
   };

   deadline_sorted_timer_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Append one result word, reporting the head deadline and count as they stand now.
   function automatic void record_word(logic [OUTCOME_BITS-1:0] outcome,
                                       logic [HANDLE_FIELD_BITS-1:0] handle, logic last);
      timer_result_type word;
      word.outcome       = outcome;
      word.handle        = handle;
      word.next_deadline = (timer_total == 0) ? NO_DEADLINE : {1'b0, timer_deadline[0]};
      word.count         = COUNT_FIELD_BITS'(timer_total);
      word.last          = last;
      step_words = {step_words, word};
   endfunction

   // Advance the shadow row by one request and collect its result words in step_words.
   function automatic void apply_timer_request(logic kind, logic [TIME_BITS-1:0] now,
                                               logic [DELAY_BITS-1:0] delay,
                                               logic [HANDLE_FIELD_BITS-1:0] handle);
      logic [NEXT_BITS-1:0]         sum;
      logic [TIME_BITS-1:0]         due;
      logic [HANDLE_FIELD_BITS-1:0] popped;
      int                           slot;
      int                           pops;
      step_words.delete();
      if (kind == REQ_SCHEDULE) begin
         // clamp negative delays to zero, saturate the sum
         sum = {1'b0, now} + (delay[DELAY_BITS-1] ? '0 : NEXT_BITS'(delay));
         due = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
         if (timer_total >= DEPTH) begin
            record_word(OUT_REJECTED, '0, 1'b1);
         end else begin
            slot = 0;
            while (slot < timer_total && timer_deadline[slot] <= due) slot++;
            for (int i = timer_total; i > slot; i--) begin
               timer_deadline[i] = timer_deadline[i-1];
               timer_owner[i]    = timer_owner[i-1];
            end
            timer_deadline[slot] = due;
            timer_owner[slot]    = handle;
            timer_total++;
            record_word(OUT_SCHEDULED, '0, 1'b1);
         end
      end else begin
         pops = 0;
         while (timer_total > 0 && timer_deadline[0] <= now) begin
            popped = timer_owner[0];
            for (int i = 1; i < timer_total; i++) begin
               timer_deadline[i-1] = timer_deadline[i];
               timer_owner[i-1]    = timer_owner[i];
            end
            timer_total--;
            record_word(OUT_EXPIRED, popped, timer_total == 0 || timer_deadline[0] > now);
            pops++;
         end
         if (pops == 0) record_word(OUT_NONE_DUE, '0, 1'b1);
      end
   endfunction

   // Offer one request word, hold it until taken, then log what it owes.
   // Valid stays high on return so back-to-back words never drop it.
   task automatic send_word(logic kind, logic [TIME_BITS-1:0] now,
                            logic [DELAY_BITS-1:0] delay,
                            logic [HANDLE_FIELD_BITS-1:0] handle,
                            logic typed, timer_result_type typed_word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {handle, delay, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_timer_request(kind, now, delay, handle);
      if (typed) begin
         outcome_backlog = {outcome_backlog, typed_word};
      end else begin
         foreach (step_words[i]) outcome_backlog = {outcome_backlog, step_words[i]};
      end
      requests_sent++;
   endtask

   // Draw one request: mostly a timeline that creeps forward with short delays,
   // with scattered far-off times, odd delays and full flushes as noise.
   task automatic send_random_request();
      logic                  kind;
      logic [TIME_BITS-1:0]  now;
      logic [DELAY_BITS-1:0] delay;
      logic [31:0]           bits;
      logic [31:0]           upper;
      clock_now = clock_now + $urandom_range(0, 60);
      now  = clock_now;
      kind = ($urandom_range(0, 99) < 35) ? REQ_EXPIRE : REQ_SCHEDULE;
      if ($urandom_range(0, 19) == 0) begin
         bits  = $urandom;
         upper = $urandom;
         now   = {upper[15:0], bits};
      end
      bits = $urandom;
      case ($urandom_range(0, 9))
         0: delay = {1'b1, bits[30:0]};
         1: delay = bits;
         default: delay = $urandom_range(0, 400);
      endcase
      if (kind == REQ_EXPIRE && $urandom_range(0, 24) == 0) now = TIME_MAX;
      bits = $urandom;
      send_word(kind, now, delay, bits[7:0], 1'b0, '0);
   endtask

   // Receiver: random back-pressure, overridden by the long hold-off.
   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(0, 99) >= stall_pct);
   end

   // Long hold-off: freeze the result side while the sender keeps pushing.
   initial begin
      hold_rsp = 1'b0;
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Compare every accepted result word against the oldest owed word.
   always @(posedge clock) begin
      timer_result_type got;
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.outcome       = rsp_tuser;
         got.handle        = rsp_tdata[7:0];
         got.next_deadline = rsp_tdata[56:8];
         got.count         = rsp_tdata[61:57];
         got.last          = rsp_tlast;
         if (outcome_backlog.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected word outcome=%0d handle=%h next=%h count=%0d last=%b",
                        $realtime, got.outcome, got.handle, got.next_deadline, got.count,
                        got.last);
         end else begin
            want = outcome_backlog.pop_front();
            outcome_seen[want.outcome]++;
            if (got !== want) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: want/got out %0d/%0d hnd %h/%h nxt %h/%h cnt %0d/%0d lst %b/%b",
                           $realtime, want.outcome, got.outcome, want.handle, got.handle,
                           want.next_deadline, got.next_deadline, want.count, got.count,
                           want.last, got.last);
            end
         end
      end
   end

   // Hard stop for a hung block.
   initial begin
      #2_000_000;
      $display("** deadline_sorted_timer_queue: FAILED **");
      $finish;
   end

   initial begin
      timer_result_type typed_word;
      int               drain_cycles;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = REQ_SCHEDULE;
      req_tdata     = '0;
      pressure_go   = 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      failures      = 0;
      requests_sent = 0;
      timer_total   = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
      clock_now     = TIME_BITS'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: corners first, then fill, reject and drain.
      foreach (directed_rows[i]) begin
         typed_word.outcome       = directed_rows[i].outcome;
         typed_word.handle        = directed_rows[i].out_handle;
         typed_word.next_deadline = directed_rows[i].next_deadline;
         typed_word.count         = directed_rows[i].count;
         typed_word.last          = 1'b1;
         send_word(directed_rows[i].kind, directed_rows[i].now, directed_rows[i].delay,
                   directed_rows[i].handle, directed_rows[i].typed, typed_word);
      end

      // Random phases: steady with the long hold-off, sparse sender, stalling receiver, both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               pressure_go   = 1'b1;
            end
            1: begin
               send_idle_pct = 64;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 64;
            end
            default: begin
               send_idle_pct = 24;
               stall_pct     = 24;
            end
         endcase
         repeat (RANDOM_PER_PHASE) send_random_request();
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every owed word, up to a timeout, then let the bench idle before the final check.
      drain_cycles = 0;
      while (outcome_backlog.size() != 0 && drain_cycles < 50000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      if (outcome_backlog.size() != 0) begin
         failures += outcome_backlog.size();
         $display("%0d result words never arrived", outcome_backlog.size());
      end

      $display("Ran %0d requests with back-pressure phases and one long hold-off;",
               requests_sent);
      $display("checked %0d scheduled, %0d rejected, %0d expired, %0d nothing-due words.",
               outcome_seen[OUT_SCHEDULED], outcome_seen[OUT_REJECTED],
               outcome_seen[OUT_EXPIRED], outcome_seen[OUT_NONE_DUE]);
      if (failures == 0) begin
         $display("** deadline_sorted_timer_queue: PASSED **");
      end else begin
         $display("** deadline_sorted_timer_queue: FAILED **");
      end
      $finish;
   end

endmodule
